[src/modular_power_and_division_macros.svh]
// assertion macros for the modular power and division block
`ifndef MODULAR_POWER_AND_DIVISION_MACROS_SVH
`define MODULAR_POWER_AND_DIVISION_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define MPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define MPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPD_ASSERT(label, clk, rst_n, prop, msg)
`define MPD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[src/mpd_pkg.sv]
// shared types and constants for the modular power and division block
package mpd_pkg;

    localparam int W  = 31;
    localparam int CW = $clog2(W);

    localparam logic [W-1:0]  MODULUS_RESET = W'(1000000007);
    localparam logic [W-1:0]  MODULUS_MIN   = W'(2);
    localparam logic [W-1:0]  ONE           = W'(1);
    localparam logic [CW-1:0] CNT_LAST      = CW'(W - 1);

    localparam logic OP_POWER  = 1'b0;
    localparam logic OP_DIVIDE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_LOOP,
        S_MUL,
        S_SQR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic         start;
        logic [W-1:0] x;
        logic [W-1:0] y;
    } t_mm_req;

    typedef struct packed {
        logic         done;
        logic [W-1:0] prod;
    } t_mm_rsp;

endpackage

[src/mpd_mulmod.sv]
// bit-serial modular multiplier: one bit of y per cycle, msb first
module mpd_mulmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mpd_pkg::t_mm_req            i_req,
    input  logic [mpd_pkg::W-1:0]       i_mod,
    output mpd_pkg::t_mm_rsp            o_rsp
);

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [mpd_pkg::CW-1:0]   r_cnt, n_cnt;
    logic [mpd_pkg::W-1:0]    r_acc, n_acc;
    logic [mpd_pkg::W-1:0]    r_x, n_x;
    logic [mpd_pkg::W-1:0]    r_y, n_y;

    logic [mpd_pkg::W+1:0]    t_sum;
    logic [mpd_pkg::W+1:0]    m1;
    logic [mpd_pkg::W+1:0]    m2;
    logic [mpd_pkg::W+1:0]    red;

    // acc and x below m, so 2*acc + x stays below 3m
    always_comb begin
        m1    = {2'b00, i_mod};
        m2    = {1'b0, i_mod, 1'b0};
        t_sum = {1'b0, r_acc, 1'b0} + {2'b00, (r_y[mpd_pkg::W-1] ? r_x : '0)};
        if (t_sum >= m2) begin
            red = t_sum - m2;
        end else if (t_sum >= m1) begin
            red = t_sum - m1;
        end else begin
            red = t_sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = mpd_pkg::CNT_LAST;
            n_acc  = '0;
            n_x    = i_req.x;
            n_y    = i_req.y;
        end else if (r_busy) begin
            n_acc = red[mpd_pkg::W-1:0];
            n_y   = {r_y[mpd_pkg::W-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

[src/modular_power_and_division.sv]
// top level: sequencer for square-and-multiply around one shared modular multiplier
//
//  channel   signals                                      handshake
//  request   i_op, i_first_value, i_second_value          start & !busy
//  result    o_result                                     o_result_valid, one cycle
//  config    i_cfg_wdata (modulus)                        i_cfg_we
//
// each multiply holds the sequencer through issue, 31 bit steps and the done strobe
// busy spans the reductions, multiplies and squarings plus the passes through the loop state
// after a run, the result strobe comes in the first cycle with busy low
// a modulus below two answers in the cycle after the request, busy stays low
// reset sets the modulus to 1000000007; results cannot be stalled

`include "modular_power_and_division_macros.svh"

module modular_power_and_division (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [mpd_pkg::W-1:0]       i_first_value,
    input  logic [mpd_pkg::W-1:0]       i_second_value,
    output logic                        o_result_valid,
    output logic [mpd_pkg::W-1:0]       o_result,
    input  logic                        i_cfg_we,
    input  logic [mpd_pkg::W-1:0]       i_cfg_wdata
);

    mpd_pkg::t_state          r_state, n_state;
    logic                     r_pend, n_pend;
    logic                     r_valid, n_valid;
    logic [mpd_pkg::W-1:0]    r_modulus;
    logic                     r_op, n_op;
    logic [mpd_pkg::W-1:0]    r_a, n_a;
    logic [mpd_pkg::W-1:0]    r_b, n_b;
    logic [mpd_pkg::W-1:0]    r_exp, n_exp;
    logic [mpd_pkg::W-1:0]    r_acc, n_acc;
    logic [mpd_pkg::W-1:0]    r_sq, n_sq;
    logic [mpd_pkg::W-1:0]    r_result, n_result;

    mpd_pkg::t_mm_req         mm_req;
    mpd_pkg::t_mm_rsp         mm_rsp;
    logic                     accept;
    logic                     accept_run;
    logic [mpd_pkg::W-1:0]    exp_shr;

    assign busy       = (r_state != mpd_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign accept_run = accept && (r_modulus >= mpd_pkg::MODULUS_MIN);
    assign exp_shr    = {1'b0, r_exp[mpd_pkg::W-1:1]};

    mpd_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .i_mod   (r_modulus),
        .o_rsp   (mm_rsp)
    );

    // operand select for the shared multiplier
    always_comb begin
        mm_req.start = 1'b0;
        mm_req.x     = r_acc;
        mm_req.y     = r_sq;
        case (r_state)
            mpd_pkg::S_RED_A: begin
                mm_req.x = mpd_pkg::ONE;
                mm_req.y = r_a;
            end
            mpd_pkg::S_RED_B: begin
                mm_req.x = mpd_pkg::ONE;
                mm_req.y = r_b;
            end
            mpd_pkg::S_MUL: begin
                mm_req.x = r_acc;
                mm_req.y = r_sq;
            end
            mpd_pkg::S_SQR: begin
                mm_req.x = r_sq;
                mm_req.y = r_sq;
            end
            mpd_pkg::S_FIN: begin
                mm_req.x = r_a;
                mm_req.y = r_acc;
            end
            default: begin
                mm_req.x = r_acc;
                mm_req.y = r_sq;
            end
        endcase
        if ((r_state inside {mpd_pkg::S_RED_A, mpd_pkg::S_RED_B, mpd_pkg::S_MUL,
                             mpd_pkg::S_SQR, mpd_pkg::S_FIN}) && !r_pend) begin
            mm_req.start = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pend   = r_pend;
        n_valid  = 1'b0;
        n_op     = r_op;
        n_a      = r_a;
        n_b      = r_b;
        n_exp    = r_exp;
        n_acc    = r_acc;
        n_sq     = r_sq;
        n_result = r_result;
        if (mm_req.start) begin
            n_pend = 1'b1;
        end
        if (mm_rsp.done) begin
            n_pend = 1'b0;
        end
        case (r_state)
            mpd_pkg::S_IDLE: begin
                if (accept) begin
                    n_op = i_op;
                    n_a  = i_first_value;
                    n_b  = i_second_value;
                    if (r_modulus < mpd_pkg::MODULUS_MIN) begin
                        n_result = '0;
                        n_valid  = 1'b1;
                    end else begin
                        n_state = mpd_pkg::S_RED_A;
                    end
                end
            end
            mpd_pkg::S_RED_A: begin
                if (mm_rsp.done) begin
                    n_a = mm_rsp.prod;
                    if (r_op == mpd_pkg::OP_POWER) begin
                        n_sq    = mm_rsp.prod;
                        n_exp   = r_b;
                        n_acc   = mpd_pkg::ONE;
                        n_state = mpd_pkg::S_LOOP;
                    end else begin
                        n_state = mpd_pkg::S_RED_B;
                    end
                end
            end
            mpd_pkg::S_RED_B: begin
                if (mm_rsp.done) begin
                    if (mm_rsp.prod == '0) begin
                        // divisor congruent to zero
                        n_result = '0;
                        n_valid  = 1'b1;
                        n_state  = mpd_pkg::S_IDLE;
                    end else begin
                        n_sq    = mm_rsp.prod;
                        n_exp   = r_modulus - mpd_pkg::MODULUS_MIN;
                        n_acc   = mpd_pkg::ONE;
                        n_state = mpd_pkg::S_LOOP;
                    end
                end
            end
            mpd_pkg::S_LOOP: begin
                if (r_exp == '0) begin
                    if (r_op == mpd_pkg::OP_DIVIDE) begin
                        n_state = mpd_pkg::S_FIN;
                    end else begin
                        n_result = r_acc;
                        n_valid  = 1'b1;
                        n_state  = mpd_pkg::S_IDLE;
                    end
                end else if (r_exp[0]) begin
                    n_state = mpd_pkg::S_MUL;
                end else begin
                    // even and nonzero: shifted exponent is still nonzero
                    n_exp   = exp_shr;
                    n_state = mpd_pkg::S_SQR;
                end
            end
            mpd_pkg::S_MUL: begin
                if (mm_rsp.done) begin
                    n_acc = mm_rsp.prod;
                    n_exp = exp_shr;
                    if (exp_shr != '0) begin
                        n_state = mpd_pkg::S_SQR;
                    end else begin
                        n_state = mpd_pkg::S_LOOP;
                    end
                end
            end
            mpd_pkg::S_SQR: begin
                if (mm_rsp.done) begin
                    n_sq    = mm_rsp.prod;
                    n_state = mpd_pkg::S_LOOP;
                end
            end
            mpd_pkg::S_FIN: begin
                if (mm_rsp.done) begin
                    n_result = mm_rsp.prod;
                    n_valid  = 1'b1;
                    n_state  = mpd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mpd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpd_pkg::S_IDLE;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_exp    <= n_exp;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mpd_pkg::MODULUS_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

    `MPD_ASSERT(a_result_when_idle, i_clk, i_rst_n, r_valid |-> !busy, "strobe while busy")
    `MPD_ASSERT(a_done_was_issued, i_clk, i_rst_n, mm_rsp.done |-> r_pend, "done without issue")
    `MPD_ASSERT(a_accept_goes_busy, i_clk, i_rst_n, accept_run |=> busy, "request not started")
    `MPD_ASSERT(a_idle_no_pend, i_clk, i_rst_n, !busy |-> !r_pend, "multiply pending in idle")

endmodule
